FILE: rtl/assert_macros.svh
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the buffer cache tag manager
// Holds the action codes, device command codes, FSM states and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned BlkW         = 32;
  localparam int unsigned HandleW      = 4;
  localparam int unsigned MaskW        = 16;
  localparam int unsigned RefW         = 8;
  localparam int unsigned CntW         = 32;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_DIRTY  = 3'd2,
    ACT_WRITE  = 3'd3,
    ACT_FLUSH  = 3'd4,
    ACT_REL    = 3'd5,
    ACT_BAD6   = 3'd6,
    ACT_BAD7   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RSVD  = 2'd3
  } dev_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HIT_SCAN,
    ST_HIT_DONE,
    ST_VIC_SCAN,
    ST_VIC_DONE,
    ST_WB_EMIT,
    ST_FILL,
    ST_FILL_EMIT,
    ST_WR_EMIT,
    ST_FL_SCAN,
    ST_FL_EMIT,
    ST_REL,
    ST_FINAL
  } state_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_WB,
    EMIT_READ,
    EMIT_FINAL
  } emit_e;

  // Controller to datapath.
  typedef struct packed {
    logic   load;       // capture input item
    logic   clear_all;  // init
    logic   scan_rst;   // restart the scan counter
    logic   scan_step;  // advance the scan counter
    logic   hit_take;   // apply hit to found slot
    logic   vic_take;   // allocate victim entry to the requested block
    logic   fill_ok;    // mark allocated entry valid
    logic   fill_bad;   // release allocated entry
    logic   set_dirty;
    logic   rel;
    logic   fail;       // set sticky status
    emit_e  emit;       // write an output item
    logic   ready_set;
  } bbc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    action_e act;
    logic    ready;
    logic    scan_end;   // scan counter at last position
    logic    cur_match;  // current scan slot is a hit
    logic    cur_free;   // current scan slot has zero count
    logic    cur_flush;  // current flush slot is valid and dirty
    logic    found;      // a hit/victim slot has been latched
    logic    vic_dirty;
    logic    wb_fail;    // device write of the selected slot fails
    logic    fill_fail;
    logic    in_range;
    logic    slot_valid;
    logic    out_busy;   // output register still full
  } bbc_sts_t;

endpackage
`default_nettype wire

FILE: rtl/bbc_ctrl.sv
// ----------------------------------------------------------------------------
// bbc_ctrl: sequencer of the buffer cache tag manager
// Walks one item through its scan and emit steps and drives the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bbc_ctrl
  import bbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  bbc_sts_t  sts_i,
  output bbc_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        case (sts_i.act)
          ACT_INIT:   state_d = ST_FINAL;
          ACT_LOOKUP: state_d = sts_i.ready ? ST_HIT_SCAN : ST_FINAL;
          ACT_DIRTY:  state_d = ST_FINAL;
          ACT_WRITE:  state_d = (sts_i.ready && sts_i.in_range && sts_i.slot_valid) ?
                                ST_WR_EMIT : ST_FINAL;
          ACT_FLUSH:  state_d = sts_i.ready ? ST_FL_SCAN : ST_FINAL;
          ACT_REL:    state_d = ST_REL;
          default:    state_d = ST_FINAL;
        endcase
      end
      ST_HIT_SCAN: if (sts_i.cur_match || sts_i.scan_end) state_d = ST_HIT_DONE;
      ST_HIT_DONE: state_d = sts_i.found ? ST_FINAL : ST_VIC_SCAN;
      ST_VIC_SCAN: if (sts_i.cur_free || sts_i.scan_end) state_d = ST_VIC_DONE;
      ST_VIC_DONE: begin
        if (!sts_i.found)        state_d = ST_FINAL;
        else if (sts_i.vic_dirty) state_d = ST_WB_EMIT;
        else                      state_d = ST_FILL;
      end
      ST_WB_EMIT: if (!sts_i.out_busy) state_d = sts_i.wb_fail ? ST_FINAL : ST_FILL;
      ST_FILL: state_d = ST_FILL_EMIT;
      ST_FILL_EMIT: if (!sts_i.out_busy) state_d = ST_FINAL;
      ST_WR_EMIT: if (!sts_i.out_busy) state_d = ST_FINAL;
      ST_FL_SCAN: begin
        if (sts_i.cur_flush) state_d = ST_FL_EMIT;
        else if (sts_i.scan_end) state_d = ST_FINAL;
      end
      ST_FL_EMIT: if (!sts_i.out_busy) state_d = sts_i.scan_end ? ST_FINAL : ST_FL_SCAN;
      ST_REL: state_d = ST_FINAL;
      ST_FINAL: if (!sts_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    cmd_o.emit = EMIT_NONE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_DECODE: begin
        case (sts_i.act)
          ACT_INIT: begin
            cmd_o.clear_all = 1'b1;
            cmd_o.ready_set = 1'b1;
          end
          ACT_LOOKUP: cmd_o.fail = !sts_i.ready;
          ACT_DIRTY:  cmd_o.set_dirty = 1'b1;
          ACT_WRITE:  cmd_o.fail = !(sts_i.ready && sts_i.in_range && sts_i.slot_valid);
          ACT_FLUSH:  cmd_o.fail = !sts_i.ready;
          ACT_REL:    ;
          default:    cmd_o.fail = 1'b1;
        endcase
      end
      ST_HIT_SCAN: cmd_o.scan_step = 1'b1;
      ST_HIT_DONE: begin
        cmd_o.scan_rst = 1'b1;
        cmd_o.hit_take = sts_i.found;
      end
      ST_VIC_SCAN: cmd_o.scan_step = 1'b1;
      ST_VIC_DONE: cmd_o.fail = !sts_i.found;
      ST_WB_EMIT: if (!sts_i.out_busy) begin
        cmd_o.emit = EMIT_WB;
        cmd_o.fail = sts_i.wb_fail;
      end
      ST_FILL: cmd_o.vic_take = 1'b1;
      ST_FILL_EMIT: if (!sts_i.out_busy) begin
        cmd_o.emit     = EMIT_READ;
        cmd_o.fill_ok  = !sts_i.fill_fail;
        cmd_o.fill_bad = sts_i.fill_fail;
        cmd_o.fail     = sts_i.fill_fail;
      end
      ST_WR_EMIT: if (!sts_i.out_busy) begin
        cmd_o.emit = EMIT_WB;
        cmd_o.fail = sts_i.wb_fail;
      end
      ST_FL_SCAN: cmd_o.scan_step = !sts_i.cur_flush;
      ST_FL_EMIT: if (!sts_i.out_busy) begin
        cmd_o.emit      = EMIT_WB;
        cmd_o.fail      = sts_i.wb_fail;
        cmd_o.scan_step = 1'b1;
      end
      ST_REL: cmd_o.rel = 1'b1;
      ST_FINAL: if (!sts_i.out_busy) cmd_o.emit = EMIT_FINAL;
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_load_decode, clk_i, rst_ni, cmd_o.load, state_q == ST_DECODE,
               "accepted item did not reach decode")
  `ASSERT_CLK(a_final_idle, clk_i, rst_ni,
              !(cmd_o.emit == EMIT_FINAL) || state_d == ST_IDLE,
              "final item without return to idle")
  `ASSERT_CLK(a_emit_free, clk_i, rst_ni,
              cmd_o.emit == EMIT_NONE || !sts_i.out_busy,
              "emit into a full output register")

endmodule
`default_nettype wire

FILE: rtl/bbc_dpath.sv
// ----------------------------------------------------------------------------
// bbc_dpath: tag store, recency ranks, counters and output register
// Holds all per-slot state, scans one slot per cycle when stepped, builds items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bbc_dpath
  import bbc_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [2:0]         action_i,
  input  wire logic [BlkW-1:0]    block_number_i,
  input  wire logic [HandleW-1:0] slot_i,
  input  wire logic [MaskW-1:0]   writeback_fail_mask_i,
  input  wire logic               fill_fail_i,
  input  bbc_cmd_t                cmd_i,
  output bbc_sts_t                sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    status_o,
  output logic [HandleW-1:0]      result_slot_o,
  output logic                    was_hit_o,
  output logic [1:0]              device_command_o,
  output logic [BlkW-1:0]         command_block_o,
  output logic [HandleW-1:0]      command_slot_o,
  output logic                    last_o,
  output logic [CntW-1:0]         hit_count_o,
  output logic [CntW-1:0]         miss_count_o,
  output logic [CntW-1:0]         eviction_count_o,
  output logic [CntW-1:0]         writeback_count_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam logic [SW-1:0] TopRank = SW'(SLOTS - 1);

  // Per-slot state.
  logic [BlkW-1:0] blk_q   [SLOTS];
  logic [SLOTS-1:0] valid_q, dirty_q;
  logic [RefW-1:0] refs_q  [SLOTS];
  logic [SW-1:0]   rank_q  [SLOTS];
  logic            ready_q;
  logic [CntW-1:0] hits_q, miss_q, evict_q, wbs_q;

  // Captured item.
  action_e         act_q;
  logic [BlkW-1:0] req_blk_q;
  logic [HandleW-1:0] req_slot_q;
  logic [MaskW-1:0] mask_q;
  logic            ffail_q;

  // Scan state: position counter and the latched slot.
  logic [SW-1:0]   pos_q;
  logic [SW-1:0]   sel_q;
  logic            found_q;
  logic            fail_q;
  logic            hit_q;

  // Find the slot holding a given rank (rank is a permutation).
  logic [SW-1:0] rank_slot;
  logic [SW-1:0] want_rank;
  always_comb begin
    want_rank = (act_q == ACT_LOOKUP && !found_q && hit_q) ? pos_q : pos_q;
    rank_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (rank_q[i] == want_rank) rank_slot = SW'(i);
    end
  end

  // Hit scan walks ranks top down, victim scan bottom up, flush slot order.
  logic          hit_phase_q;
  logic [SW-1:0] hit_rank;
  logic [SW-1:0] cur_slot;
  assign hit_rank = TopRank - pos_q;
  logic [SW-1:0] rs_hit;
  always_comb begin
    rs_hit = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (rank_q[i] == hit_rank) rs_hit = SW'(i);
    end
  end
  always_comb begin
    if (act_q == ACT_FLUSH)  cur_slot = pos_q;
    else if (hit_phase_q)    cur_slot = rs_hit;
    else                     cur_slot = rank_slot;
  end

  logic [SW-1:0] hslot;
  assign hslot    = SW'(req_slot_q);

  logic [SW-1:0] wb_slot;
  logic          wb_fail;
  assign wb_slot = (act_q == ACT_WRITE) ? hslot : (act_q == ACT_FLUSH) ? pos_q : sel_q;
  assign wb_fail = (32'(wb_slot) < MaskW) ? mask_q[wb_slot[$clog2(MaskW)-1:0]] : 1'b0;

  logic slot_ok;
  assign slot_ok = in_range_f(req_slot_q);
  function automatic logic in_range_f(input logic [HandleW-1:0] s);
    return 32'(s) < SLOTS;
  endfunction

  // Output register.
  logic out_busy;
  assign out_busy = out_valid_o && !out_ready_i;

  // Status to controller.
  always_comb begin
    sts_o.act        = act_q;
    sts_o.ready      = ready_q;
    sts_o.scan_end   = (pos_q == TopRank);
    sts_o.cur_match  = valid_q[cur_slot] && (blk_q[cur_slot] == req_blk_q);
    sts_o.cur_free   = (refs_q[cur_slot] == '0);
    sts_o.cur_flush  = valid_q[pos_q] && dirty_q[pos_q];
    sts_o.found      = found_q;
    sts_o.vic_dirty  = dirty_q[sel_q];
    sts_o.wb_fail    = wb_fail;
    sts_o.fill_fail  = ffail_q;
    sts_o.in_range   = slot_ok;
    sts_o.slot_valid = valid_q[hslot];
    sts_o.out_busy   = out_busy;
  end

  // Release helper: rank update when a count falls to zero.
  logic          mk_recent;
  logic [SW-1:0] mk_slot;
  always_comb begin
    mk_recent = 1'b0;
    mk_slot   = sel_q;
    if (cmd_i.rel && slot_ok && refs_q[hslot] == RefW'(1)) begin
      mk_recent = 1'b1;
      mk_slot   = hslot;
    end
    if (cmd_i.fill_bad) begin
      mk_recent = 1'b1;
      mk_slot   = sel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        blk_q[i]  <= '0;
        refs_q[i] <= '0;
        rank_q[i] <= SW'(i);
      end
      valid_q     <= '0;
      dirty_q     <= '0;
      ready_q     <= 1'b0;
      hits_q      <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      wbs_q       <= '0;
      pos_q       <= '0;
      sel_q       <= '0;
      found_q     <= 1'b0;
      fail_q      <= 1'b0;
      hit_q       <= 1'b0;
      hit_phase_q <= 1'b0;
      out_valid_o <= 1'b0;
      act_q       <= ACT_INIT;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.load) begin
        act_q       <= action_e'(action_i);
        req_blk_q   <= block_number_i;
        req_slot_q  <= slot_i;
        mask_q      <= writeback_fail_mask_i;
        ffail_q     <= fill_fail_i;
        fail_q      <= 1'b0;
        hit_q       <= 1'b0;
        found_q     <= 1'b0;
        hit_phase_q <= 1'b1;
        pos_q       <= '0;
      end
      if (cmd_i.scan_rst) pos_q <= '0;
      if (cmd_i.scan_step && !(sts_o.scan_end)) pos_q <= pos_q + SW'(1);
      if (cmd_i.scan_step && !found_q && act_q == ACT_LOOKUP) begin
        if (hit_phase_q ? sts_o.cur_match : sts_o.cur_free) begin
          found_q <= 1'b1;
          sel_q   <= cur_slot;
        end
      end
      if (cmd_i.hit_take) begin
        if (refs_q[sel_q] != '1) refs_q[sel_q] <= refs_q[sel_q] + RefW'(1);
        hits_q <= hits_q + CntW'(1);
        hit_q  <= 1'b1;
      end else if (act_q == ACT_LOOKUP && hit_phase_q && cmd_i.scan_rst) begin
        hit_phase_q <= 1'b0;
      end
      if (cmd_i.fail) fail_q <= 1'b1;
      if (cmd_i.clear_all) begin
        for (int i = 0; i < SLOTS; i++) begin
          blk_q[i]  <= '0;
          refs_q[i] <= '0;
          rank_q[i] <= SW'(i);
        end
        valid_q <= '0;
        dirty_q <= '0;
        hits_q  <= '0;
        miss_q  <= '0;
        evict_q <= '0;
        wbs_q   <= '0;
      end
      if (cmd_i.ready_set) ready_q <= 1'b1;
      if (cmd_i.set_dirty && slot_ok) dirty_q[hslot] <= 1'b1;
      if (cmd_i.emit == EMIT_WB && !wb_fail) begin
        dirty_q[wb_slot] <= 1'b0;
        wbs_q <= wbs_q + CntW'(1);
      end
      if (cmd_i.vic_take) begin
        if (valid_q[sel_q]) evict_q <= evict_q + CntW'(1);
        blk_q[sel_q]   <= req_blk_q;
        valid_q[sel_q] <= 1'b0;
        dirty_q[sel_q] <= 1'b0;
        refs_q[sel_q]  <= RefW'(1);
        miss_q         <= miss_q + CntW'(1);
      end
      if (cmd_i.fill_ok) valid_q[sel_q] <= 1'b1;
      if (cmd_i.fill_bad) refs_q[sel_q] <= '0;
      if (cmd_i.rel && slot_ok && refs_q[hslot] != '0) refs_q[hslot] <= refs_q[hslot] - RefW'(1);
      if (mk_recent) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (rank_q[i] > rank_q[mk_slot]) rank_q[i] <= rank_q[i] - SW'(1);
        end
        rank_q[mk_slot] <= TopRank;
      end
      if (cmd_i.emit != EMIT_NONE) out_valid_o <= 1'b1;
    end
  end

  // Output payload; a write command carries the counters from before its own
  // write-back is counted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EMIT_NONE) begin
      hit_count_o       <= hits_q;
      miss_count_o      <= miss_q;
      eviction_count_o  <= evict_q;
      writeback_count_o <= wbs_q;
      status_o          <= 1'b0;
      result_slot_o     <= '0;
      was_hit_o         <= 1'b0;
      last_o            <= 1'b0;
      command_block_o   <= '0;
      command_slot_o    <= '0;
      device_command_o  <= CMD_NONE;
      case (cmd_i.emit)
        EMIT_WB: begin
          device_command_o <= CMD_WRITE;
          command_block_o  <= blk_q[wb_slot];
          command_slot_o   <= HandleW'(wb_slot);
        end
        EMIT_READ: begin
          device_command_o <= CMD_READ;
          command_block_o  <= req_blk_q;
          command_slot_o   <= HandleW'(sel_q);
        end
        EMIT_FINAL: begin
          last_o    <= 1'b1;
          status_o  <= fail_q;
          was_hit_o <= hit_q;
          result_slot_o <= (act_q == ACT_LOOKUP && !fail_q) ? HandleW'(sel_q) : '0;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_one_emit_busy, clk_i, rst_ni,
              cmd_i.emit == EMIT_NONE || !out_busy, "output overwritten")
  `ASSERT_NEXT(a_hit_count, clk_i, rst_ni, cmd_i.hit_take,
               hits_q == $past(hits_q) + CntW'(1), "hit counter did not advance")

endmodule
`default_nettype wire

FILE: rtl/block_buffer_cache_lru_top.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_top: LRU buffer cache tag manager
// Handles one action item at a time and emits device commands and status.
// ----------------------------------------------------------------------------
// One item is taken at a time. Lookup walks the recency ranks one slot per
// cycle, first for a hit and then for a free victim; flush walks the slots
// in order, one a cycle, and stops at each dirty slot to emit its write-back.
// Each result item sits in an output register; the next result waits until
// it is taken.
`timescale 1ns / 1ps
`default_nettype none
module block_buffer_cache_lru_top
  import bbc_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         action_i,
  input  wire logic [BlkW-1:0]    block_number_i,
  input  wire logic [HandleW-1:0] slot_i,
  input  wire logic [MaskW-1:0]   writeback_fail_mask_i,
  input  wire logic               fill_fail_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    status_o,
  output logic [HandleW-1:0]      result_slot_o,
  output logic                    was_hit_o,
  output logic [1:0]              device_command_o,
  output logic [BlkW-1:0]         command_block_o,
  output logic [HandleW-1:0]      command_slot_o,
  output logic                    last_o,
  output logic [CntW-1:0]         hit_count_o,
  output logic [CntW-1:0]         miss_count_o,
  output logic [CntW-1:0]         eviction_count_o,
  output logic [CntW-1:0]         writeback_count_o
);

  bbc_cmd_t cmd;
  bbc_sts_t sts;

  // Sequencer: owns the input handshake.
  bbc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // Tag store and output register.
  bbc_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk_i,
    .rst_ni,
    .action_i,
    .block_number_i,
    .slot_i,
    .writeback_fail_mask_i,
    .fill_fail_i,
    .cmd_i (cmd),
    .sts_o (sts),
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .result_slot_o,
    .was_hit_o,
    .device_command_o,
    .command_block_o,
    .command_slot_o,
    .last_o,
    .hit_count_o,
    .miss_count_o,
    .eviction_count_o,
    .writeback_count_o
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LRU buffer cache tag manager
// Drives action items through the valid/ready input channel and predicts
// every device command and final status from its own model of the tag
// store, recency ranks, reference counts and statistics counters.
// ----------------------------------------------------------------------------
module tb;
  import bbc_pkg::*;

  localparam int unsigned NSLOT     = 16;
  localparam int unsigned NRANDOM   = 405;
  localparam int unsigned CALM_TAIL = 50;   // items at the end with no idling

  typedef struct {
    action_e     act;
    logic [31:0] blk;
    logic [3:0]  slot;
    logic [15:0] mask;
    logic        fill;
    bit          drain;  // hold off until every expected result has come
  } cache_req_t;

  typedef struct {
    logic        status;
    logic [3:0]  rslot;
    logic        hit;
    dev_cmd_e    cmd;
    logic [31:0] cblk;
    logic [3:0]  cslot;
    logic        last;
    logic [31:0] hits, misses, evicts, wbacks;
  } cache_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  action_i = '0;
  logic [31:0] block_number_i = '0;
  logic [3:0]  slot_i = '0;
  logic [15:0] writeback_fail_mask_i = '0;
  logic        fill_fail_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        status_o, was_hit_o, last_o;
  logic [3:0]  result_slot_o, command_slot_o;
  logic [1:0]  device_command_o;
  logic [31:0] command_block_o;
  logic [31:0] hit_count_o, miss_count_o, eviction_count_o, writeback_count_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  block_buffer_cache_lru_top dut (.*);

  // --------------------------------------------------------------------------
  // Predictor state: one tag entry per slot plus the recency ranks.
  // --------------------------------------------------------------------------
  logic [31:0] tag_blk [NSLOT];
  logic        tag_valid [NSLOT];
  logic        tag_dirty [NSLOT];
  logic [7:0]  tag_refs [NSLOT];
  logic [3:0]  tag_rank [NSLOT];
  logic        cache_ready;
  logic [31:0] cnt_hit, cnt_miss, cnt_evict, cnt_wb;

  cache_req_t  pending_reqs[$];
  cache_resp_t expected_resps[$];
  cache_req_t  cur_req;
  int unsigned n_items, n_accepted;
  int unsigned mismatches;
  int unsigned in_gap, out_stall;

  task automatic wipe_tags();
    for (int i = 0; i < NSLOT; i++) begin
      tag_blk[i] = '0;
      tag_valid[i] = 1'b0;
      tag_dirty[i] = 1'b0;
      tag_refs[i] = '0;
      tag_rank[i] = 4'(i);
    end
    cnt_hit = '0;
    cnt_miss = '0;
    cnt_evict = '0;
    cnt_wb = '0;
  endtask

  task automatic push_resp(logic st, logic [3:0] rs, logic h, dev_cmd_e c,
                           logic [31:0] b, logic [3:0] cs, logic l);
    cache_resp_t r;
    r.status = st; r.rslot = rs; r.hit = h; r.cmd = c;
    r.cblk = b; r.cslot = cs; r.last = l;
    r.hits = cnt_hit; r.misses = cnt_miss; r.evicts = cnt_evict; r.wbacks = cnt_wb;
    expected_resps.push_back(r);
  endtask

  function automatic int slot_at_rank(int r);
    for (int i = 0; i < NSLOT; i++)
      if (tag_rank[i] == 4'(r)) return i;
    return -1;
  endfunction

  task automatic promote(int s);
    logic [3:0] old;
    old = tag_rank[s];
    for (int i = 0; i < NSLOT; i++)
      if (tag_rank[i] > old) tag_rank[i]--;
    tag_rank[s] = 4'(NSLOT - 1);
  endtask

  task automatic drop_ref(int s);
    if (tag_refs[s] != 0) begin
      tag_refs[s]--;
      if (tag_refs[s] == 0) promote(s);
    end
  endtask

  // Emit a write command; returns 1 when the device write succeeds.
  task automatic flush_slot(int s, logic [15:0] mask, output bit ok);
    push_resp(1'b0, '0, 1'b0, CMD_WRITE, tag_blk[s], 4'(s), 1'b0);
    ok = !mask[s];
    if (ok) begin
      tag_dirty[s] = 1'b0;
      cnt_wb++;
    end
  endtask

  // Work out every result that one accepted item causes.
  task automatic predict_item(cache_req_t q);
    logic       st;
    logic [3:0] rs;
    logic       h;
    int         found, s;
    bit         ok;
    st = 1'b0; rs = '0; h = 1'b0; found = -1;
    case (q.act)
      ACT_INIT: begin
        wipe_tags();
        cache_ready = 1'b1;
      end
      ACT_LOOKUP: begin
        if (!cache_ready) begin
          st = 1'b1;
        end else begin
          for (int r = NSLOT - 1; r >= 0 && found < 0; r--) begin
            s = slot_at_rank(r);
            if (s >= 0 && tag_valid[s] && tag_blk[s] == q.blk) found = s;
          end
          if (found >= 0) begin
            if (tag_refs[found] != 8'hff) tag_refs[found]++;
            cnt_hit++;
            rs = 4'(found);
            h = 1'b1;
          end else begin
            for (int r = 0; r < NSLOT && found < 0; r++) begin
              s = slot_at_rank(r);
              if (s >= 0 && tag_refs[s] == 0) found = s;
            end
            ok = 1'b1;
            if (found < 0) st = 1'b1;
            else if (tag_dirty[found]) flush_slot(found, q.mask, ok);
            if (found >= 0 && !ok) st = 1'b1;
            if (found >= 0 && ok) begin
              if (tag_valid[found]) cnt_evict++;
              tag_blk[found] = q.blk;
              tag_valid[found] = 1'b0;
              tag_dirty[found] = 1'b0;
              tag_refs[found] = 8'd1;
              cnt_miss++;
              push_resp(1'b0, '0, 1'b0, CMD_READ, q.blk, 4'(found), 1'b0);
              if (q.fill) begin
                drop_ref(found);
                st = 1'b1;
              end else begin
                tag_valid[found] = 1'b1;
                rs = 4'(found);
              end
            end
          end
        end
      end
      ACT_DIRTY: tag_dirty[q.slot] = 1'b1;
      ACT_WRITE: begin
        if (!cache_ready || !tag_valid[q.slot]) st = 1'b1;
        else begin
          flush_slot(q.slot, q.mask, ok);
          if (!ok) st = 1'b1;
        end
      end
      ACT_FLUSH: begin
        if (!cache_ready) st = 1'b1;
        else
          for (int i = 0; i < NSLOT; i++)
            if (tag_valid[i] && tag_dirty[i]) begin
              flush_slot(i, q.mask, ok);
              if (!ok) st = 1'b1;
            end
      end
      ACT_REL: drop_ref(q.slot);
      default: st = 1'b1;
    endcase
    push_resp(st, rs, h, CMD_NONE, '0, '0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [31:0] blk_pool [20];

  function automatic cache_req_t mk_req(action_e a, logic [31:0] b, logic [3:0] s,
                                        logic [15:0] m, logic f);
    cache_req_t q;
    q.act = a; q.blk = b; q.slot = s; q.mask = m; q.fill = f; q.drain = 1'b0;
    return q;
  endfunction

  // Mostly well-formed traffic on a small block pool so hits, evictions and
  // a full cache all occur; a little init and illegal actions as noise.
  function automatic cache_req_t rand_req();
    cache_req_t q;
    int unsigned pick;
    logic [15:0] m;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       m = '0;
      1:       m = 16'hffff;
      default: m = 16'($urandom & $urandom & $urandom);
    endcase
    q = mk_req(ACT_LOOKUP, blk_pool[$urandom_range(0, 19)], 4'($urandom),
               m, ($urandom_range(0, 9) == 0));
    if ($urandom_range(0, 9) == 0) q.blk = $urandom;
    if (pick < 42)      q.act = ACT_LOOKUP;
    else if (pick < 68) q.act = ACT_REL;
    else if (pick < 80) q.act = ACT_DIRTY;
    else if (pick < 89) q.act = ACT_WRITE;
    else if (pick < 95) q.act = ACT_FLUSH;
    else if (pick < 97) q.act = ACT_INIT;
    else q.act = ($urandom_range(0, 1) != 0) ? ACT_BAD6 : ACT_BAD7;
    return q;
  endfunction

  initial begin
    cache_req_t q;
    wipe_tags();
    cache_ready = 1'b0;
    blk_pool[0] = '0;
    blk_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < 20; i++) blk_pool[i] = $urandom;

    // Directed opening: the not-yet-initialised cases first.
    pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'h1234, 4'd0, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_WRITE, '0, 4'd2, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_FLUSH, '0, 4'd0, 16'hffff, 1'b0));
    pending_reqs.push_back(mk_req(ACT_DIRTY, '0, 4'd3, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_REL, '0, 4'd15, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_BAD6, 32'hffff_ffff, 4'd15, 16'hffff, 1'b1));
    pending_reqs.push_back(mk_req(ACT_BAD7, '0, 4'd0, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_INIT, '0, 4'd0, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'hffff_ffff, 4'd0, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_LOOKUP, '0, 4'd0, '0, 1'b1));
    pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'hffff_ffff, 4'd0, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_DIRTY, '0, 4'd15, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_WRITE, '0, 4'd15, 16'hffff, 1'b0));
    pending_reqs.push_back(mk_req(ACT_WRITE, '0, 4'd15, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_DIRTY, '0, 4'd15, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_FLUSH, '0, 4'd0, 16'hffff, 1'b0));
    pending_reqs.push_back(mk_req(ACT_FLUSH, '0, 4'd0, 16'h0000, 1'b0));
    pending_reqs.push_back(mk_req(ACT_REL, '0, 4'd15, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_REL, '0, 4'd15, '0, 1'b0));
    pending_reqs.push_back(mk_req(ACT_WRITE, '0, 4'd0, '0, 1'b0));
    for (int i = 0; i < NRANDOM; i++) begin
      q = rand_req();
      q.drain = (i == 100 || i == 250);
      pending_reqs.push_back(q);
    end
    n_items = pending_reqs.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_accepted == n_items && expected_resps.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: hold each item until taken, idle in bursts, drain when asked.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
      n_accepted <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_item(cur_req);
        n_accepted <= n_accepted + 1;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the item until it is accepted
      end else if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain &&
                    (expected_resps.size() != 0 || (in_valid_i && in_ready_o)))) begin
        in_valid_i <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        action_i <= cur_req.act;
        block_number_i <= cur_req.blk;
        slot_i <= cur_req.slot;
        writeback_fail_mask_i <= cur_req.mask;
        fill_fail_i <= cur_req.fill;
        if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
          in_gap <= $urandom_range(1, 10);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall in bursts, compare each result with the oldest expected.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    cache_resp_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall <= 0;
      mismatches <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_resps.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result with nothing expected: cmd %0d last %0b",
                     device_command_o, last_o);
        end else begin
          e = expected_resps.pop_front();
          if (status_o !== e.status || result_slot_o !== e.rslot ||
              was_hit_o !== e.hit || device_command_o !== e.cmd ||
              command_block_o !== e.cblk || command_slot_o !== e.cslot ||
              last_o !== e.last || hit_count_o !== e.hits ||
              miss_count_o !== e.misses || eviction_count_o !== e.evicts ||
              writeback_count_o !== e.wbacks) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display({"mismatch: exp st %0b rs %0d hit %0b cmd %0d blk %h cs %0d ",
                        "last %0b cnt %0d/%0d/%0d/%0d; got st %0b rs %0d hit %0b ",
                        "cmd %0d blk %h cs %0d last %0b cnt %0d/%0d/%0d/%0d"},
                       e.status, e.rslot, e.hit, e.cmd, e.cblk, e.cslot, e.last,
                       e.hits, e.misses, e.evicts, e.wbacks,
                       status_o, result_slot_o, was_hit_o, device_command_o,
                       command_block_o, command_slot_o, last_o, hit_count_o,
                       miss_count_o, eviction_count_o, writeback_count_o);
          end
        end
      end
      // Stall the receiver in bursts, but not during the calm tail.
      if (out_stall != 0) begin
        out_ready_i <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        out_stall <= $urandom_range(0, 9);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bbc_pkg.sv
rtl/bbc_ctrl.sv
rtl/bbc_dpath.sv
rtl/block_buffer_cache_lru_top.sv
tb/tb.sv
